// ===== hdl/packbits_encoder_macros.svh =====
// Assertion macros used by the encoder back end.
`ifndef PACKBITS_ENCODER_MACROS_SVH
`define PACKBITS_ENCODER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PKB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PKB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pkb_pkg.sv =====
// Package with the shared types, constants and the lookahead decision function.
`timescale 1ns / 1ps
`default_nettype none
package pkb_pkg;

    localparam int MAX_LITERALS = 128;
    localparam int MAX_RUN      = 128;

    localparam int LIT_IDX_W = $clog2(MAX_LITERALS);
    localparam int LIT_CNT_W = $clog2(MAX_LITERALS + 1);
    localparam int RUN_W     = $clog2(MAX_RUN);
    localparam int RAM_AW    = LIT_IDX_W + 1;
    localparam int RAM_DEPTH = 2 * MAX_LITERALS;

    localparam logic [7:0] END_MARKER = 8'd128;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int WORD_BYTES = 8;
    localparam int ACC_CNT_W  = $clog2(WORD_BYTES);
    localparam int OUT_CNT_W  = 4;

    typedef enum logic [1:0] {
        CMD_RUN,
        CMD_LIT,
        CMD_MARK
    } t_cmd_kind;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_END_DEC,
        FS_END_FLUSH,
        FS_END_MARK
    } t_fst;

    // One entry of the command queue between the front and the back.
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] hdr;   // run header, or literal count minus one
        logic [7:0] sym;   // run symbol
        logic       bank;  // literal bank to read
        logic       last;  // last command caused by this item
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    typedef struct packed {
        logic [RUN_W-1:0]     run_len;
        logic                 sym_we;
        logic [LIT_CNT_W-1:0] lit_cnt;
        logic                 lit_we;
        logic                 push;
        t_cmd_kind            kind;
        logic [7:0]           hdr;
    } t_dec;

    // Decides the fate of the held byte given the byte that follows it.
    function automatic t_dec pkb_decide(input logic [7:0]           c,
                                        input logic                 has_next,
                                        input logic [7:0]           nxt,
                                        input logic [RUN_W-1:0]     run_len,
                                        input logic [LIT_CNT_W-1:0] lit_cnt);
        t_dec                 d;
        logic [LIT_CNT_W-1:0] inc;
        d.run_len = run_len;
        d.sym_we  = 1'b0;
        d.lit_cnt = lit_cnt;
        d.lit_we  = 1'b0;
        d.push    = 1'b0;
        d.kind    = CMD_RUN;
        d.hdr     = 8'(10'd256 - 10'(run_len));
        inc       = LIT_CNT_W'(lit_cnt + 1'b1);
        if (has_next && (nxt == c)) begin
            if (run_len >= RUN_W'(MAX_RUN - 1)) begin
                d.push    = 1'b1;
                d.run_len = '0;
            end else begin
                d.run_len = RUN_W'(run_len + 1'b1);
                d.sym_we  = 1'b1;
                if (lit_cnt != '0) begin
                    d.push    = 1'b1;
                    d.kind    = CMD_LIT;
                    d.hdr     = 8'(lit_cnt - 1'b1);
                    d.lit_cnt = '0;
                end
            end
        end else if (run_len != '0) begin
            d.push    = 1'b1;
            d.run_len = '0;
        end else begin
            d.lit_we  = 1'b1;
            d.lit_cnt = inc;
            if (inc == LIT_CNT_W'(MAX_LITERALS)) begin
                d.push    = 1'b1;
                d.kind    = CMD_LIT;
                d.hdr     = 8'(MAX_LITERALS - 1);
                d.lit_cnt = '0;
            end
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pkb_lit_ram.sv =====
// Two-bank literal store with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pkb_lit_ram (
    input  wire logic                  i_clk,
    input  wire pkb_pkg::t_ram_wr      i_wr,
    input  wire logic [pkb_pkg::RAM_AW-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);
    import pkb_pkg::*;

    logic [7:0] r_mem [RAM_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== hdl/pkb_cmd_fifo.sv =====
// Short command queue between the classifying front and the byte-emitting back.
`timescale 1ns / 1ps
`default_nettype none
module pkb_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pkb_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output pkb_pkg::t_cmd      o_cmd
);
    import pkb_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            r_count <= n_count;
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

// ===== hdl/pkb_front.sv =====
// Front end: accepts input items, keeps the lookahead state and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module pkb_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_data,
    input  wire logic            i_has,
    input  wire logic            i_end,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output pkb_pkg::t_cmd        o_cmd,
    output pkb_pkg::t_ram_wr     o_ram_wr,
    input  wire pkb_pkg::t_rel   i_rel
);
    import pkb_pkg::*;

    t_fst                 r_state,     n_state;
    logic [7:0]           r_held_byte, n_held_byte;
    logic                 r_held_valid, n_held_valid;
    logic [RUN_W-1:0]     r_run_len,   n_run_len;
    logic [7:0]           r_run_sym,   n_run_sym;
    logic [LIT_CNT_W-1:0] r_lit_cnt,   n_lit_cnt;
    logic                 r_wr_bank,   n_wr_bank;
    logic [1:0]           r_busy,      n_busy;

    t_dec dec;
    logic can_go;
    logic use_dec;
    logic last_flag;

    always_comb begin
        n_state      = r_state;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_run_len    = r_run_len;
        n_run_sym    = r_run_sym;
        n_lit_cnt    = r_lit_cnt;
        n_wr_bank    = r_wr_bank;
        n_busy       = r_busy;
        o_ready      = 1'b0;
        o_push       = 1'b0;
        o_cmd        = '0;
        o_ram_wr     = '0;
        use_dec      = 1'b0;
        last_flag    = 1'b0;

        // In the idle state the held byte is judged against the new byte;
        // at the end of a stream it is judged as followed by nothing.
        dec    = pkb_decide(r_held_byte, (r_state == FS_IDLE), i_data,
                            r_run_len, r_lit_cnt);
        can_go = !i_q_full && !r_busy[r_wr_bank];

        case (r_state)
            FS_IDLE: begin
                o_ready = can_go;
                if (i_valid && can_go) begin
                    if (i_has) begin
                        use_dec      = r_held_valid;
                        n_held_byte  = i_data;
                        n_held_valid = 1'b1;
                    end
                    last_flag = !i_end;
                    if (i_end) begin
                        n_state = FS_END_DEC;
                    end
                end
            end
            FS_END_DEC: begin
                if (can_go) begin
                    use_dec = r_held_valid;
                    n_state = FS_END_FLUSH;
                end
            end
            FS_END_FLUSH: begin
                if (can_go) begin
                    if (r_lit_cnt != '0) begin
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_LIT;
                        o_cmd.hdr  = 8'(r_lit_cnt - 1'b1);
                        n_lit_cnt  = '0;
                    end
                    n_state = FS_END_MARK;
                end
            end
            FS_END_MARK: begin
                if (!i_q_full) begin
                    o_push       = 1'b1;
                    o_cmd.kind   = CMD_MARK;
                    o_cmd.last   = 1'b1;
                    n_held_byte  = '0;
                    n_held_valid = 1'b0;
                    n_run_len    = '0;
                    n_run_sym    = '0;
                    n_lit_cnt    = '0;
                    n_state      = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase

        if (use_dec) begin
            n_run_len = dec.run_len;
            n_lit_cnt = dec.lit_cnt;
            if (dec.sym_we) begin
                n_run_sym = r_held_byte;
            end
            o_ram_wr.en   = dec.lit_we;
            o_ram_wr.addr = {r_wr_bank, r_lit_cnt[LIT_IDX_W-1:0]};
            o_ram_wr.data = r_held_byte;
            o_push        = dec.push;
            o_cmd.kind    = dec.kind;
            o_cmd.hdr     = dec.hdr;
            o_cmd.sym     = r_run_sym;
            o_cmd.last    = last_flag;
        end

        o_cmd.bank = r_wr_bank;

        // A queued literal flush owns its bank until the back has read it.
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (o_push && (o_cmd.kind == CMD_LIT)) begin
            n_busy[r_wr_bank] = 1'b1;
            n_wr_bank         = ~r_wr_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= FS_IDLE;
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_run_len    <= '0;
            r_run_sym    <= '0;
            r_lit_cnt    <= '0;
            r_wr_bank    <= 1'b0;
            r_busy       <= '0;
        end else begin
            r_state      <= n_state;
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_run_len    <= n_run_len;
            r_run_sym    <= n_run_sym;
            r_lit_cnt    <= n_lit_cnt;
            r_wr_bank    <= n_wr_bank;
            r_busy       <= n_busy;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pkb_back.sv =====
// Back end: expands queued commands into bytes and packs them into output words.
`timescale 1ns / 1ps
`default_nettype none
`include "packbits_encoder_macros.svh"
module pkb_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire pkb_pkg::t_cmd               i_q_cmd,
    output logic                             o_q_pop,
    output logic [pkb_pkg::RAM_AW-1:0]       o_rd_addr,
    input  wire logic [7:0]                  i_rd_data,
    output pkb_pkg::t_rel                    o_rel,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [63:0]                      o_bytes,
    output logic [pkb_pkg::OUT_CNT_W-1:0]    o_count,
    output logic                             o_last,
    output logic                             o_done
);
    import pkb_pkg::*;

    logic                 r_active;
    t_cmd                 r_cmd;
    logic [LIT_CNT_W-1:0] r_pos;
    logic [63:0]          r_acc;
    logic [ACC_CNT_W-1:0] r_acc_cnt;
    logic                 r_out_valid;
    logic [63:0]          r_out_bytes;
    logic [OUT_CNT_W-1:0] r_out_cnt;
    logic                 r_out_last;
    logic                 r_out_done;

    logic [7:0]           cur_byte;
    logic [LIT_CNT_W-1:0] final_pos;
    logic [LIT_CNT_W-1:0] pos_m1;
    logic                 cur_last;
    logic                 step_end;
    logic                 completes;
    logic                 out_free;
    logic                 adv;
    logic [63:0]          merged;

    always_comb begin
        case (r_cmd.kind)
            CMD_RUN: begin
                cur_byte  = (r_pos == '0) ? r_cmd.hdr : r_cmd.sym;
                final_pos = LIT_CNT_W'(1);
            end
            CMD_LIT: begin
                cur_byte  = (r_pos == '0) ? r_cmd.hdr : i_rd_data;
                final_pos = LIT_CNT_W'(r_cmd.hdr + 1'b1);
            end
            CMD_MARK: begin
                cur_byte  = END_MARKER;
                final_pos = '0;
            end
            default: begin
                cur_byte  = '0;
                final_pos = '0;
            end
        endcase
        pos_m1    = LIT_CNT_W'(r_pos - 1'b1);
        cur_last  = (r_pos == final_pos);
        step_end  = cur_last && r_cmd.last;
        completes = (r_acc_cnt == ACC_CNT_W'(WORD_BYTES - 1)) || step_end;
        out_free  = !r_out_valid || i_ready;
        adv       = r_active && (!completes || out_free);
        merged    = r_acc | (64'(cur_byte) << {r_acc_cnt, 3'b000});
        // Address the entry for the byte shown next cycle: the read is registered.
        o_rd_addr = {r_cmd.bank,
                     adv ? r_pos[LIT_IDX_W-1:0] : pos_m1[LIT_IDX_W-1:0]};
        o_q_pop   = !r_active && i_q_valid;
        o_rel.valid = adv && cur_last && (r_cmd.kind == CMD_LIT);
        o_rel.bank  = r_cmd.bank;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (adv && completes) begin
            r_out_bytes <= merged;
            r_out_cnt   <= OUT_CNT_W'(r_acc_cnt) + 1'b1;
            r_out_last  <= step_end;
            r_out_done  <= step_end && (r_cmd.kind == CMD_MARK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_active <= 1'b1;
                r_pos    <= '0;
            end else if (adv) begin
                if (cur_last) begin
                    r_active <= 1'b0;
                end
                r_pos <= LIT_CNT_W'(r_pos + 1'b1);
            end
            if (adv) begin
                if (completes) begin
                    r_acc     <= '0;
                    r_acc_cnt <= '0;
                end else begin
                    r_acc     <= merged;
                    r_acc_cnt <= ACC_CNT_W'(r_acc_cnt + 1'b1);
                end
            end
            if (adv && completes) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_bytes = r_out_bytes;
    assign o_count = r_out_cnt;
    assign o_last  = r_out_last;
    assign o_done  = r_out_done;

    `PKB_ASSERT_SAME(a_mark_ends_step, r_active && (r_cmd.kind == CMD_MARK), r_cmd.last, "end marker is not the last command of its item")
    `PKB_ASSERT_SAME(a_empty_acc_zero, r_acc_cnt == '0, r_acc == '0, "empty word accumulator holds stale bytes")
    `PKB_ASSERT_SAME(a_done_is_last, r_out_valid && r_out_done, r_out_last, "end marker word is not the last word of its item")
    `PKB_ASSERT_NEXT(a_release_idle, o_rel.valid, !r_active, "back still busy after releasing a literal bank")

endmodule
`default_nettype wire

// ===== hdl/packbits_encoder.sv =====
// Top level of the PackBits run-length encoder with packed output words.
//
//   Channel   Direction  tdata (low bit up)               tuser       tlast
//   s_axis    in         data_byte[7:0]                   has_byte    end_of_stream
//   m_axis    out        packed_bytes[63:0], byte_count   stream_done last_of_step
//                        [67:64], zero fill [71:68]
//
// An item without an end mark is taken while the command queue has room and the
// literal bank being filled is free. An end-of-stream item holds the input while the
// front queues the final decision, the literal flush and the end marker. The back
// emits one encoded byte per cycle unless a finished word is stalled at its output,
// and takes the next command only once idle: a literal flush yields its header and its
// bytes, a run its header and symbol, the end marker one byte; that byte loop sets the
// sustained rate. Reset is synchronous and active low; the literal store needs
// no clearing pass. Either side may stall at any time; a full queue or a busy literal
// bank drops s_axis tready, and a stalled output word holds the back until taken.
`timescale 1ns / 1ps
`default_nettype none
module packbits_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // data_byte
    input  wire logic        i_s_axis_tuser,   // has_byte
    input  wire logic        i_s_axis_tlast,   // end_of_stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,   // packed_bytes, byte_count, zero fill
    output logic             o_m_axis_tuser,   // stream_done
    output logic             o_m_axis_tlast    // last_of_step
);
    import pkb_pkg::*;

    // Front to queue.
    logic    q_push;
    t_cmd    q_in;
    logic    q_full;
    // Queue to back.
    logic    q_pop;
    logic    q_valid;
    t_cmd    q_out;
    // Literal store traffic and bank hand-back.
    t_ram_wr ram_wr;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    t_rel    rel;
    // Output word fields.
    logic [63:0]          out_bytes;
    logic [OUT_CNT_W-1:0] out_cnt;

    // The front classifies each byte against the held lookahead byte and
    // writes literals into one bank while the back may read the other.
    pkb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_data   (i_s_axis_tdata),
        .i_has    (i_s_axis_tuser),
        .i_end    (i_s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in),
        .o_ram_wr (ram_wr),
        .i_rel    (rel)
    );

    pkb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    pkb_lit_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The back walks each command byte by byte and packs up to eight bytes
    // per output word, closing a word early at the end of an item's output.
    pkb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_out),
        .o_q_pop   (q_pop),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_rel     (rel),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_bytes   (out_bytes),
        .o_count   (out_cnt),
        .o_last    (o_m_axis_tlast),
        .o_done    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {4'b0000, out_cnt, out_bytes};

endmodule
`default_nettype wire

// ===== verif/tb_packbits_encoder.sv =====
// Self-checking testbench for packbits_encoder: byte streams checked word by word.
`timescale 1ns / 1ps
module tb_packbits_encoder;
    import pkb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000; // cycles with no item moving on either side
    localparam int HOLD_CYCLES    = 300;  // long receiver hold-off that backs up the block
    localparam int DRAIN_CYCLES   = 300;  // covers a full literal flush after the last word
    localparam int RANDOM_ITEMS   = 110;
    localparam int IDLE_PCT       = 7;
    localparam int MAX_STEP_BYTES = 136;  // 17 words of 8 bytes

    // One encoded output word as the predictor expects it.
    typedef struct {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
        logic        done;
    } t_enc_word;

    typedef enum {
        STREAM_SOLID,
        STREAM_RUNS,
        STREAM_LITERALS,
        STREAM_MIXED
    } t_stream_kind;

    // Predicts the encoded words for every accepted input item and checks the words that
    // leave the block against them in order.
    class packbits_scoreboard;
        logic [7:0]  held_byte;
        bit          held_valid;
        int unsigned run_matches;   // the run holds run_matches + 1 bytes
        logic [7:0]  run_sym;
        logic [7:0]  lit_buf [MAX_LITERALS];
        int unsigned lit_count;
        logic [7:0]  step_bytes[$];
        t_enc_word   words_due[$];
        int unsigned errors;

        function new();
            errors = 0;
            reset_state();
        endfunction

        function void reset_state();
            held_byte   = '0;
            held_valid  = 1'b0;
            run_matches = 0;
            run_sym     = '0;
            lit_count   = 0;
        endfunction

        function void put(int unsigned b);
            if (step_bytes.size() < MAX_STEP_BYTES) begin
                step_bytes.push_back(8'(b));
            end
        endfunction

        function void flush_literals();
            if (lit_count == 0) begin
                return;
            end
            put(lit_count - 1);
            for (int i = 0; i < lit_count; i++) begin
                put(lit_buf[i]);
            end
            lit_count = 0;
        endfunction

        function void emit_run();
            put(257 - (run_matches + 1));
            put(run_sym);
            run_matches = 0;
        endfunction

        // The byte that follows c decides whether c grows a run, ends one or is a literal.
        function void decide(logic [7:0] c, bit has_next, logic [7:0] nxt);
            if (has_next && nxt == c) begin
                if (run_matches >= MAX_RUN - 1) begin
                    emit_run();
                end else begin
                    run_matches++;
                    run_sym = c;
                    flush_literals();
                end
            end else if (run_matches > 0) begin
                emit_run();
            end else begin
                lit_buf[lit_count % MAX_LITERALS] = c;
                lit_count++;
                if (lit_count >= MAX_LITERALS) begin
                    flush_literals();
                end
            end
        endfunction

        function void note_input(logic [7:0] data, bit has, bit eos);
            t_enc_word   w;
            int unsigned n_words;
            step_bytes.delete();
            if (has) begin
                if (held_valid) begin
                    decide(held_byte, 1'b1, data);
                end
                held_byte  = data;
                held_valid = 1'b1;
            end
            if (eos) begin
                // The held byte is treated as followed by a differing byte.
                if (held_valid) begin
                    decide(held_byte, 1'b0, 8'h00);
                end
                flush_literals();
                put(END_MARKER);
                reset_state();
            end
            n_words = (step_bytes.size() + 7) / 8;
            for (int k = 0; k < n_words; k++) begin
                w.bytes = '0;
                w.count = '0;
                for (int j = 0; j < 8 && k * 8 + j < step_bytes.size(); j++) begin
                    w.bytes[8 * j +: 8] = step_bytes[k * 8 + j];
                    w.count = w.count + 4'd1;
                end
                w.last = (k + 1 == n_words);
                w.done = eos && w.last;
                words_due.push_back(w);
            end
        endfunction

        function void check_word(logic [71:0] tdata, logic tuser, logic tlast);
            t_enc_word want;
            if (words_due.size() == 0) begin
                $display("%0t: word %h arrived with nothing expected", $time, tdata);
                errors++;
                return;
            end
            want = words_due.pop_front();
            if (tdata[63:0] !== want.bytes) begin
                $display("%0t: packed bytes expected %h actual %h",
                         $time, want.bytes, tdata[63:0]);
                errors++;
            end
            if (tdata[67:64] !== want.count) begin
                $display("%0t: byte count expected %0d actual %0d",
                         $time, want.count, tdata[67:64]);
                errors++;
            end
            if (tlast !== want.last) begin
                $display("%0t: last of step expected %b actual %b", $time, want.last, tlast);
                errors++;
            end
            if (tuser !== want.done) begin
                $display("%0t: stream done expected %b actual %b", $time, want.done, tuser);
                errors++;
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = '0;
    logic        s_has   = 1'b0;
    logic        s_eos   = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [71:0] m_data;
    logic        m_user;
    logic        m_last;

    packbits_scoreboard sb;
    int          src_idle_pct = IDLE_PCT;
    int          snk_idle_pct = IDLE_PCT;
    bit          hold_req     = 1'b0;
    int unsigned item_count   = 0;

    always #1 i_clk = ~i_clk;

    packbits_encoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_has),
        .i_s_axis_tlast  (s_eos),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    // Offers one item, with an occasional one-cycle gap first, and returns at the edge
    // where the block takes it. Items with neither a byte nor an end are not counted.
    task automatic send_item(input logic [7:0] d, input logic has, input logic eos);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        s_has   <= has;
        s_eos   <= eos;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_input(d, has, eos);
        if (has || eos) begin
            item_count++;
        end
    endtask

    // Sends one whole stream of len bytes shaped by kind, ending either on the last byte
    // or with a separate end-only item. Ignored filler items are sprinkled in.
    task automatic send_stream(input t_stream_kind kind, input int unsigned len);
        logic [7:0] b;
        logic [7:0] prev;
        bit         ended;
        prev  = 8'($urandom_range(255));
        ended = 1'b0;
        for (int unsigned i = 0; i < len; i++) begin
            case (kind)
                STREAM_SOLID: begin
                    b = prev;
                end
                STREAM_RUNS: begin
                    b = ($urandom_range(99) < 75) ? prev : 8'($urandom_range(255));
                end
                STREAM_LITERALS: begin
                    b = 8'($urandom_range(255));
                    if (b == prev) begin
                        b = b + 8'd1;
                    end
                end
                default: begin
                    b = ($urandom_range(99) < 50) ? prev : 8'($urandom_range(255));
                end
            endcase
            if ($urandom_range(99) < 4) begin
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            if (i == len - 1 && $urandom_range(1) == 1) begin
                send_item(b, 1'b1, 1'b1);
                ended = 1'b1;
            end else begin
                send_item(b, 1'b1, 1'b0);
            end
            prev = b;
        end
        if (!ended) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    // Receiver: takes words at random, checks each one, and on request holds off for a
    // long stretch so that the block backs up and stalls its input.
    initial begin : sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_valid && m_ready) begin
                sb.check_word(m_data, m_user, m_last);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Ends the run when nothing moves on either side for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_packbits_encoder: FAIL");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. An item with no byte and no end does nothing.
        send_item(8'h00, 1'b0, 1'b0);
        // Empty stream: only the end marker.
        send_item(8'hA5, 1'b0, 1'b1);
        // Byte and end together on a fresh stream: one literal, then the marker.
        send_item(8'hFF, 1'b1, 1'b1);
        // Short run then a literal, closed by an end-only item.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        // Literals flushed when a run begins; the run closes at the end with the byte.
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h02, 1'b1, 1'b0);
        send_item(8'h03, 1'b1, 1'b0);
        send_item(8'h03, 1'b1, 1'b0);
        send_item(8'h03, 1'b1, 1'b1);
        // End right after an end marker, with the state back at reset.
        send_item(8'h00, 1'b0, 1'b1);
        // A run that begins on the final byte.
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        // Alternating extremes, with a filler item in the middle of the stream.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h3C, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);

        // A full literal store, with the receiver holding off so the input backs up.
        hold_req = 1'b1;
        send_stream(STREAM_LITERALS, 131);

        // A run past its maximum length, sent with no idling on either side.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_stream(STREAM_SOLID, 130);
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;

        // Random streams of mixed shape and short length.
        item_count = 0;
        while (item_count < RANDOM_ITEMS) begin
            send_stream(t_stream_kind'($urandom_range(STREAM_RUNS, STREAM_MIXED)),
                        $urandom_range(0, 12));
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_packbits_encoder: PASS");
        end else begin
            $display("tb_packbits_encoder: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pkb_pkg.sv
hdl/pkb_lit_ram.sv
hdl/pkb_cmd_fifo.sv
hdl/pkb_front.sv
hdl/pkb_back.sv
hdl/packbits_encoder.sv
verif/tb_packbits_encoder.sv
